// ===== hw/rtl/gdws_pkg.sv =====
`timescale 1ns / 1ps

package gdws_pkg;

	localparam int CNT_W     = 32;
	localparam int SETTLE_W  = 10;
	localparam int TOTAL_W   = 32;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(50);

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic               stable_level;
		logic               stable_valid;
		logic               stable_changed;
		logic               settling;
		logic [TOTAL_W-1:0] bounce_total;
		logic [TOTAL_W-1:0] stable_total;
	} res_t;

endpackage

// ===== hw/rtl/gdws_if.sv =====
`timescale 1ns / 1ps

interface gdws_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic pin_level;

	modport source (output valid, output cmd, output pin_level, input ready);
	modport sink   (input valid, input cmd, input pin_level, output ready);
endinterface

interface gdws_out_if;
	import gdws_pkg::*;

	logic               valid;
	logic               ready;
	logic               stable_level;
	logic               stable_valid;
	logic               stable_changed;
	logic               settling;
	logic [TOTAL_W-1:0] bounce_total;
	logic [TOTAL_W-1:0] stable_total;

	modport source (output valid, output stable_level, output stable_valid,
		output stable_changed, output settling, output bounce_total,
		output stable_total, input ready);
	modport sink   (input valid, input stable_level, input stable_valid,
		input stable_changed, input settling, input bounce_total,
		input stable_total, output ready);
endinterface

// ===== hw/rtl/gdws_core.sv =====
`timescale 1ns / 1ps

module gdws_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gdws_pkg::SETTLE_W-1:0]   cfg_wdata,
	input  logic                            accept,
	input  logic                            cmd,
	input  logic                            pin_level,
	output gdws_pkg::res_t                  res_d
);
	import gdws_pkg::*;

	logic [SETTLE_W-1:0] settle_q;
	logic [SETTLE_W-1:0] countdown_q, countdown_d;
	logic                armed_q, armed_d;
	logic                last_seen_q, last_seen_d;
	logic                stable_bit_q, stable_bit_d;
	logic                stable_known_q, stable_known_d;
	logic [CNT_W-1:0]    bounce_cnt_q, bounce_cnt_d;
	logic [CNT_W-1:0]    stable_cnt_q, stable_cnt_d;
	logic                changed;

	always_comb begin
		countdown_d    = countdown_q;
		armed_d        = armed_q;
		last_seen_d    = last_seen_q;
		stable_bit_d   = stable_bit_q;
		stable_known_d = stable_known_q;
		bounce_cnt_d   = bounce_cnt_q;
		stable_cnt_d   = stable_cnt_q;
		changed        = 1'b0;
		if (cmd == CMD_EDGE) begin
			last_seen_d = pin_level;
			countdown_d = settle_q;
			armed_d     = 1'b1;
		end else if (armed_q) begin
			if (countdown_q > SETTLE_W'(1)) begin
				countdown_d = countdown_q - SETTLE_W'(1);
			end else begin
				// expiry tick: evaluate the pin
				countdown_d = '0;
				if (pin_level == last_seen_q) begin
					if (!stable_known_q || pin_level != stable_bit_q) begin
						stable_bit_d   = pin_level;
						stable_known_d = 1'b1;
						stable_cnt_d   = stable_cnt_q + CNT_W'(1);
						changed        = 1'b1;
					end
					armed_d = 1'b0;
				end else begin
					bounce_cnt_d = bounce_cnt_q + CNT_W'(1);
					last_seen_d  = pin_level;
					countdown_d  = settle_q;
				end
			end
		end
	end

	always_comb begin
		res_d.stable_level   = stable_bit_d;
		res_d.stable_valid   = stable_known_d;
		res_d.stable_changed = changed;
		res_d.settling       = armed_d;
		res_d.bounce_total   = TOTAL_W'(bounce_cnt_d);
		res_d.stable_total   = TOTAL_W'(stable_cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
		end else if (cfg_we) begin
			settle_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q    <= '0;
			armed_q        <= 1'b0;
			last_seen_q    <= 1'b0;
			stable_bit_q   <= 1'b0;
			stable_known_q <= 1'b0;
			bounce_cnt_q   <= '0;
			stable_cnt_q   <= '0;
		end else if (accept) begin
			countdown_q    <= countdown_d;
			armed_q        <= armed_d;
			last_seen_q    <= last_seen_d;
			stable_bit_q   <= stable_bit_d;
			stable_known_q <= stable_known_d;
			bounce_cnt_q   <= bounce_cnt_d;
			stable_cnt_q   <= stable_cnt_d;
		end
	end

	a_disarmed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> countdown_q == '0)
		else $error("countdown running while disarmed");

	a_change_known: assert property (@(posedge clk) disable iff (!arst_n)
		accept && changed |=> stable_known_q && armed_q == 1'b0)
		else $error("stable change without known level or with countdown armed");

	a_stable_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stable_cnt_q == $past(stable_cnt_q) + CNT_W'($past(changed)))
		else $error("stable counter out of step with change pulse");

endmodule

// ===== hw/rtl/gdws_out_reg.sv =====
`timescale 1ns / 1ps

module gdws_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  gdws_pkg::res_t  res_d,
	output logic            can_load,
	gdws_out_if.source      out_ch
);
	import gdws_pkg::*;

	logic valid_q;
	res_t res_q;

	// take a new item when none is held or the held one leaves in this cycle
	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid          = valid_q;
	assign out_ch.stable_level   = res_q.stable_level;
	assign out_ch.stable_valid   = res_q.stable_valid;
	assign out_ch.stable_changed = res_q.stable_changed;
	assign out_ch.settling       = res_q.settling;
	assign out_ch.bounce_total   = res_q.bounce_total;
	assign out_ch.stable_total   = res_q.stable_total;

	a_load_shown: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && res_q == $past(res_d))
		else $error("loaded item not presented");

endmodule

// ===== hw/rtl/gdws_top_dummy_placeholder.sv =====
`timescale 1ns / 1ps

module gdws_in_stage (
	input  logic        can_load,
	output logic        accept,
	output logic        cmd,
	output logic        pin_level,
	gdws_in_if.sink     in_ch
);
	// ready follows the result register; an item is taken on valid and ready
	assign in_ch.ready = can_load;
	assign accept      = in_ch.valid && can_load;
	assign cmd         = in_ch.cmd;
	assign pin_level   = in_ch.pin_level;
endmodule

// ===== hw/rtl/gpio_debounce_with_stats.sv =====
`timescale 1ns / 1ps

// channel    | dir | handshake     | payload
// pin_in     | in  | valid / ready | cmd, pin_level
// stat_out   | out | valid / ready | stable_level, stable_valid, stable_changed,
//            |     |               | settling, bounce_total, stable_total
// cfg        | in  | cfg_we        | cfg_wdata (settle time in ticks)
//
// one item per cycle while pin_in.ready is high; its result is registered and shows in the cycle after accept
// state updates and the result register load in the same cycle as accept
// pin_in.ready is low only while a result is held and stat_out.ready is low
// arst_n clears the debouncer state and stat_out.valid (the held payload is not reset); settle time resets to 50 ticks

module gpio_debounce_with_stats (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gdws_pkg::SETTLE_W-1:0]  cfg_wdata,
	gdws_in_if.sink                        pin_in,
	gdws_out_if.source                     stat_out
);
	import gdws_pkg::*;

	logic accept;
	logic can_load;
	logic cmd;
	logic pin_level;
	res_t res_d;

	gdws_in_stage u_in (
		.can_load  (can_load),
		.accept    (accept),
		.cmd       (cmd),
		.pin_level (pin_level),
		.in_ch     (pin_in)
	);

	gdws_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.cmd       (cmd),
		.pin_level (pin_level),
		.res_d     (res_d)
	);

	gdws_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res_d    (res_d),
		.can_load (can_load),
		.out_ch   (stat_out)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gdws_pkg::*;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	// directed row: either a settle time write or one item, with an optional typed result
	typedef struct {
		row_kind_t           kind;
		logic [SETTLE_W-1:0] settle;
		logic                cmd;
		logic                level;
		bit                  typed;
		logic                w_level;
		logic                w_valid;
		logic                w_changed;
		logic                w_settling;
		int                  w_bounce;
		int                  w_stable;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [SETTLE_W-1:0] cfg_wdata = '0;

	gdws_in_if  pin_if();
	gdws_out_if stat_if();

	gpio_debounce_with_stats dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pin_in    (pin_if),
		.stat_out  (stat_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// debouncer state as the predictor sees it
	logic [SETTLE_W-1:0] settle_reg = SETTLE_RESET;
	logic [SETTLE_W-1:0] count_q = '0;
	logic                armed_q = 1'b0;
	logic                last_q = 1'b0;
	logic                stable_q = 1'b0;
	logic                known_q = 1'b0;
	logic [TOTAL_W-1:0]  bounce_cnt = '0;
	logic [TOTAL_W-1:0]  stable_cnt = '0;

	res_t pending_res[$];
	int   errors = 0;
	int   snd_idle_pct = 0;
	int   rcv_stall_pct = 0;
	bit   hold_req = 1'b0;
	int   hold_left = 0;

	function automatic res_t debounce_step(logic cmd, logic level);
		res_t r;
		logic changed;
		changed = 1'b0;
		if (cmd == CMD_EDGE) begin
			last_q = level;
			count_q = settle_reg;
			armed_q = 1'b1;
		end else if (armed_q) begin
			if (count_q > 1) begin
				count_q = count_q - 1'b1;
			end else begin
				count_q = '0;
				if (level == last_q) begin
					if (!known_q || level != stable_q) begin
						stable_q = level;
						known_q = 1'b1;
						stable_cnt = stable_cnt + 1'b1;
						changed = 1'b1;
					end
					armed_q = 1'b0;
				end else begin
					// pin moved again at expiry: count a bounce and restart
					bounce_cnt = bounce_cnt + 1'b1;
					last_q = level;
					count_q = settle_reg;
				end
			end
		end
		r.stable_level = stable_q;
		r.stable_valid = known_q;
		r.stable_changed = changed;
		r.settling = armed_q;
		r.bounce_total = bounce_cnt;
		r.stable_total = stable_cnt;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
		errors++;
	endtask

	// results are taken at the rising edge
	always @(posedge clk) begin
		res_t want;
		if (arst_n && stat_if.valid && stat_if.ready) begin
			if (pending_res.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_res.pop_front();
				if (stat_if.stable_level !== want.stable_level)
					report_mismatch("stable_level", 32'(stat_if.stable_level),
						32'(want.stable_level));
				if (stat_if.stable_valid !== want.stable_valid)
					report_mismatch("stable_valid", 32'(stat_if.stable_valid),
						32'(want.stable_valid));
				if (stat_if.stable_changed !== want.stable_changed)
					report_mismatch("stable_changed", 32'(stat_if.stable_changed),
						32'(want.stable_changed));
				if (stat_if.settling !== want.settling)
					report_mismatch("settling", 32'(stat_if.settling), 32'(want.settling));
				if (stat_if.bounce_total !== want.bounce_total)
					report_mismatch("bounce_total", stat_if.bounce_total, want.bounce_total);
				if (stat_if.stable_total !== want.stable_total)
					report_mismatch("stable_total", stat_if.stable_total, want.stable_total);
			end
		end
	end

	// result side: random stalls plus an occasional long hold-off
	initial begin
		stat_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 60;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				stat_if.ready = 1'b0;
				hold_left--;
			end else begin
				stat_if.ready = ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_item(logic cmd, logic level, output res_t predicted);
		while ($urandom_range(99) < snd_idle_pct) begin
			pin_if.valid = 1'b0;
			@(negedge clk);
		end
		pin_if.valid = 1'b1;
		pin_if.cmd = cmd;
		pin_if.pin_level = level;
		do @(posedge clk); while (!pin_if.ready);
		predicted = debounce_step(cmd, level);
		@(negedge clk);
	endtask

	task automatic drain_results();
		pin_if.valid = 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_settle(logic [SETTLE_W-1:0] value);
		drain_results();
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		settle_reg = value;
	endtask

	// mostly well-formed press/release sequences, shaped from the current state
	task automatic pick_item(int edge_pct_armed, output logic cmd, output logic level);
		if (armed_q) begin
			if ($urandom_range(99) < edge_pct_armed) begin
				cmd = CMD_EDGE;
				level = 1'($urandom_range(1));
			end else begin
				cmd = CMD_TICK;
				if (count_q <= 1 && $urandom_range(99) < 80)
					level = last_q;
				else
					level = 1'($urandom_range(1));
			end
		end else if ($urandom_range(99) < 60) begin
			cmd = CMD_EDGE;
			level = ($urandom_range(99) < 70) ? ~stable_q : 1'($urandom_range(1));
		end else begin
			cmd = CMD_TICK;
			level = 1'($urandom_range(1));
		end
	endtask

	task automatic run_phase(logic [SETTLE_W-1:0] settle, int count, int edge_pct_armed);
		logic cmd;
		logic level;
		res_t predicted;
		write_settle(settle);
		for (int i = 0; i < count; i++) begin
			if (i == count / 3)
				hold_req = 1'b1;
			if (i == 2 * count / 3)
				drain_results();
			pick_item(edge_pct_armed, cmd, level);
			send_item(cmd, level, predicted);
			pending_res.push_back(predicted);
		end
	endtask

	dir_row_t dir_rows [25] = '{
		'{ROW_ITEM, 0,    CMD_TICK, 0, 1, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 1, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG,  1,    CMD_EDGE, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_EDGE, 1, 1, 0, 0, 0, 1, 0, 0},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 1, 1, 1, 1, 0, 0, 1},
		'{ROW_ITEM, 0,    CMD_EDGE, 1, 1, 1, 1, 0, 1, 0, 1},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 1, 1, 1, 0, 0, 0, 1},
		'{ROW_ITEM, 0,    CMD_EDGE, 0, 1, 1, 1, 0, 1, 0, 1},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 1, 1, 1, 0, 1, 1, 1},
		'{ROW_ITEM, 0,    CMD_TICK, 0, 1, 1, 1, 0, 1, 2, 1},
		'{ROW_ITEM, 0,    CMD_TICK, 0, 1, 0, 1, 1, 0, 2, 2},
		'{ROW_CFG,  0,    CMD_EDGE, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_EDGE, 1, 1, 0, 1, 0, 1, 2, 2},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 1, 1, 1, 1, 0, 2, 3},
		'{ROW_CFG,  3,    CMD_EDGE, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_EDGE, 0, 1, 1, 1, 0, 1, 2, 3},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG,  1023, CMD_EDGE, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_TICK, 1, 1, 1, 1, 0, 1, 3, 3},
		'{ROW_CFG,  2,    CMD_EDGE, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_EDGE, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 0,    CMD_TICK, 0, 1, 0, 1, 1, 0, 3, 4},
		'{ROW_ITEM, 0,    CMD_EDGE, 1, 0, 0, 0, 0, 0, 0, 0}
	};

	initial begin
		res_t predicted;
		res_t want;
		pin_if.valid = 1'b0;
		pin_if.cmd = CMD_EDGE;
		pin_if.pin_level = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		snd_idle_pct = 20;
		rcv_stall_pct = 48;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_settle(dir_rows[i].settle);
			end else begin
				send_item(dir_rows[i].cmd, dir_rows[i].level, predicted);
				want = predicted;
				if (dir_rows[i].typed) begin
					want.stable_level = dir_rows[i].w_level;
					want.stable_valid = dir_rows[i].w_valid;
					want.stable_changed = dir_rows[i].w_changed;
					want.settling = dir_rows[i].w_settling;
					want.bounce_total = TOTAL_W'(dir_rows[i].w_bounce);
					want.stable_total = TOTAL_W'(dir_rows[i].w_stable);
				end
				pending_res.push_back(want);
			end
		end

		run_phase(1, 200, 20);
		run_phase(0, 150, 20);

		snd_idle_pct = 48;
		rcv_stall_pct = 20;
		run_phase(4, 150, 15);
		run_phase(2, 100, 15);

		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		// long settle time: ticks only while armed so the full countdown runs out
		run_phase(60, 250, 0);
		run_phase(SETTLE_RESET, 200, 2);

		drain_results();
		repeat (4) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/gdws_pkg.sv
hw/rtl/gdws_if.sv
hw/rtl/gdws_core.sv
hw/rtl/gdws_out_reg.sv
hw/rtl/gdws_top_dummy_placeholder.sv
hw/rtl/gpio_debounce_with_stats.sv
bench/testbench.sv
